// ===== rtl/dbrf_pkg.sv =====
package dbrf_pkg;

	localparam int VW = 32;
	localparam int FB = 16;
	localparam int TW = 31;
	localparam int DW = VW + FB;
	localparam int CW = $clog2(DW + 1);

	typedef logic signed [VW-1:0] val_t;
	typedef logic [TW-1:0] tol_t;

	localparam val_t VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam val_t VMIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic [2*VW-1:0] MAXM = {{(VW+1){1'b0}}, {(VW-1){1'b1}}};

	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_SECOND = 2'd1;
	localparam logic [1:0] MODE_EVAL = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD0, OP_LOAD1, OP_LOAD2, OP_SWAP, OP_MID, OP_TSIGN,
		OP_DDER, OP_DIV1, OP_DQ, OP_M_FBD, OP_M_P, OP_M_FADB, OP_Q, OP_NEG,
		OP_M_QT, OP_M_MBQ, OP_DIV2, OP_WTOL, OP_WMB, OP_WQUOT, OP_FINAL,
		OP_DONE_OUT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_SWAP, S_MID, S_CHECK, S_DSEL, S_DWAIT1, S_M1, S_M2, S_M3,
		S_Q, S_NEG, S_M4, S_M5, S_CMP, S_DWAIT2, S_FINAL, S_DONE
	} state_t;

	typedef enum logic [1:0] {PH_IDLE, PH_LOADED, PH_WAIT, PH_DONE} phase_t;

	typedef struct packed {
		op_t  op;
		logic first;
	} cmd_t;

	typedef struct packed {
		logic conv;
		logic plain_bisect;
		logic ec_two;
		logic div_done;
		logic p_small;
		logic p_lt;
		logic out_free;
	} status_t;

	function automatic logic [VW-1:0] vabs(input val_t x);
		return x[VW-1] ? (~x) + 1'b1 : x;
	endfunction

	function automatic val_t sat_mag(input logic neg, input logic [2*VW-1:0] m);
		logic [VW-1:0] mv;
		mv = m[VW-1:0];
		if (m > MAXM)
			return neg ? VMIN : VMAX;
		return neg ? val_t'(~mv + 1'b1) : val_t'(mv);
	endfunction

	function automatic val_t sat_add(input val_t x, input val_t y);
		logic [VW:0] s;
		s = {x[VW-1], x} + {y[VW-1], y};
		if (s[VW] != s[VW-1])
			return s[VW] ? VMIN : VMAX;
		return s[VW-1:0];
	endfunction

	function automatic val_t sat_sub(input val_t x, input val_t y);
		logic [VW:0] s;
		s = {x[VW-1], x} - {y[VW-1], y};
		if (s[VW] != s[VW-1])
			return s[VW] ? VMIN : VMAX;
		return s[VW-1:0];
	endfunction

	// fixed point product, truncated toward zero and saturated
	function automatic val_t mulq(input val_t x, input val_t y);
		logic [2*VW-1:0] pr;
		logic [2*VW-1:0] m;
		pr = {{VW{1'b0}}, vabs(x)} * {{VW{1'b0}}, vabs(y)};
		m = pr >> FB;
		return sat_mag(x[VW-1] ^ y[VW-1], m);
	endfunction

endpackage

// ===== rtl/derivative_bracketing_root_finder.sv =====
// bracketing root search sequencer with derivative-assisted steps
// input channel (in_valid/in_ready): one transfer per function evaluation with
//   point, fvalue, dvalue and tolerance; mode 0 loads the first bracket end,
//   mode 1 the second end and starts a search, mode 2 returns the evaluation
//   at the last requested point; mode 3 and stray evaluations are dropped
// output channel (out_valid/out_ready): one transfer per search step, either
//   next_point to evaluate (finished low) or best_point, other_end and
//   bracketed once the bracket is within tolerance (finished high)
// a step runs through the swap, midpoint and check states; a bisection or
//   a converged bracket goes straight to the result, the derivative-secant
//   estimate adds the multiply states, and the secant slope, the step
//   quotient or both go through the shared 48-step restoring divider
// one item is in work at a time, in_ready is high only between steps
// a mode 0 item gives no result and the sequencer stays idle
// the result sits in an output register; a stalled receiver only holds the
//   next step's write-back, a new item is still taken meanwhile
// reset clears all points, values, tolerances and the extrapolation count
//   to zero, so a mode 1 item without a mode 0 item brackets against zero
module derivative_bracketing_root_finder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic signed [31:0]    point,
	input  logic signed [31:0]    fvalue,
	input  logic signed [31:0]    dvalue,
	input  logic [30:0]           tolerance,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [31:0]    next_point,
	output logic                  finished,
	output logic signed [31:0]    best_point,
	output logic signed [31:0]    other_end,
	output logic                  bracketed
);
	import dbrf_pkg::*;

	// command and status between sequencer and datapath
	cmd_t    cmd;
	status_t st;

	dbrf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode    (mode),
		.st      (st),
		.cmd     (cmd)
	);

	// points, values, step arithmetic, divider and result register
	dbrf_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.point     (point),
		.fvalue    (fvalue),
		.dvalue    (dvalue),
		.tolerance (tolerance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.next_point(next_point),
		.finished  (finished),
		.best_point(best_point),
		.other_end (other_end),
		.bracketed (bracketed)
	);

endmodule

// ===== rtl/dbrf_div.sv =====
module dbrf_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dbrf_pkg::val_t num,
	input  dbrf_pkg::val_t den,
	output logic           done,
	output dbrf_pkg::val_t quot
);
	import dbrf_pkg::*;

	logic [VW-1:0] rem_q, ud_q;
	logic [DW-1:0] dvd_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q, neg_q;
	val_t          quot_q;

	logic [VW:0]   r2;
	logic          bit_ok;
	logic [VW-1:0] r_next;
	logic [DW-1:0] dvd_next;

	always_comb begin
		r2 = {rem_q, dvd_q[DW-1]};
		bit_ok = r2 >= {1'b0, ud_q};
		r_next = bit_ok ? VW'(r2 - {1'b0, ud_q}) : r2[VW-1:0];
		dvd_next = {dvd_q[DW-2:0], bit_ok};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q && cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			ud_q <= vabs(den);
			dvd_q <= {vabs(num), {FB{1'b0}}};
			cnt_q <= CW'(DW);
			neg_q <= num[VW-1] ^ den[VW-1];
			if (den == '0)
				quot_q <= (num == '0) ? '0 : (num[VW-1] ? VMIN : VMAX);
		end else if (busy_q) begin
			rem_q <= r_next;
			dvd_q <= dvd_next;
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				quot_q <= sat_mag(neg_q, (2*VW)'(dvd_next));
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider started while busy");

endmodule

// ===== rtl/dbrf_dpath.sv =====
module dbrf_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  dbrf_pkg::cmd_t    cmd,
	output dbrf_pkg::status_t st,
	input  dbrf_pkg::val_t    point,
	input  dbrf_pkg::val_t    fvalue,
	input  dbrf_pkg::val_t    dvalue,
	input  dbrf_pkg::tol_t    tolerance,
	output logic              out_valid,
	input  logic              out_ready,
	output dbrf_pkg::val_t    next_point,
	output logic              finished,
	output dbrf_pkg::val_t    best_point,
	output dbrf_pkg::val_t    other_end,
	output logic              bracketed
);
	import dbrf_pkg::*;

	val_t pa_q, pb_q, pc_q, fa_q, da_q, fb_q, db_q, fc_q, dc_q;
	tol_t tb_q, tc_q;
	logic [1:0] ec_q;
	logic swb_q, out_valid_q;

	val_t tol_q, mb_q, ba_q, d_q, t1_q, p_q, t2_q, q_q, t3_q, t4_q, w_q;
	val_t np_q, bp_q, oe_q;
	logic fin_q, br_q;

	val_t mul_x, mul_y, prod, div_num, div_den, quot, mid, nb;
	logic [VW:0] msum;
	logic swapped, same, div_start, div_done;

	dbrf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (quot)
	);

	always_comb begin
		case (cmd.op)
			OP_M_P:    begin mul_x = t1_q; mul_y = ba_q; end
			OP_M_FADB: begin mul_x = fa_q; mul_y = db_q; end
			OP_M_QT:   begin mul_x = q_q;  mul_y = tol_q; end
			OP_M_MBQ:  begin mul_x = mb_q; mul_y = q_q; end
			default:   begin mul_x = fb_q; mul_y = d_q; end
		endcase
		prod = mulq(mul_x, mul_y);
		div_start = (cmd.op == OP_DIV1) || (cmd.op == OP_DIV2);
		div_num = (cmd.op == OP_DIV2) ? p_q : sat_sub(fb_q, fa_q);
		div_den = (cmd.op == OP_DIV2) ? q_q : ba_q;
		swapped = vabs(fc_q) < vabs(fb_q);
		same = fc_q[VW-1] ? (fvalue <= 0) : (fvalue >= 0);
		msum = {pc_q[VW-1], pc_q} + {pb_q[VW-1], pb_q};
		mid = msum[VW:1];
		nb = sat_add(pb_q, w_q);
	end

	always_comb begin
		st.conv = vabs(mb_q) <= $unsigned(tol_q);
		st.plain_bisect = (ec_q == 2'd3) || (ec_q != 2'd2 && pb_q == pa_q);
		st.ec_two = ec_q == 2'd2;
		st.div_done = div_done;
		st.p_small = (p_q <= 0) || (p_q <= t3_q);
		st.p_lt = p_q < t4_q;
		st.out_free = !out_valid_q || out_ready;
	end

	// search state, reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q <= '0; pb_q <= '0; pc_q <= '0;
			fa_q <= '0; da_q <= '0; fb_q <= '0;
			db_q <= '0; fc_q <= '0; dc_q <= '0;
			tb_q <= '0; tc_q <= '0;
			ec_q <= '0;
			swb_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_FINAL || cmd.op == OP_DONE_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_LOAD0: begin
					pb_q <= point; fb_q <= fvalue; db_q <= dvalue; tb_q <= tolerance;
				end
				OP_LOAD1: begin
					pa_q <= point; pc_q <= point;
					fa_q <= fvalue; fc_q <= fvalue;
					da_q <= dvalue; dc_q <= dvalue;
					tc_q <= tolerance;
					ec_q <= '0;
					swb_q <= 1'b0;
				end
				OP_LOAD2: begin
					fb_q <= fvalue; db_q <= dvalue; tb_q <= tolerance;
					if (same) begin
						pc_q <= pa_q; fc_q <= fa_q; dc_q <= da_q;
						tc_q <= tb_q;
						ec_q <= '0;
					end else if (swb_q) begin
						ec_q <= '0;
					end else if (ec_q != 2'd3) begin
						ec_q <= ec_q + 2'd1;
					end
				end
				OP_SWAP: begin
					if (swapped) begin
						pa_q <= pb_q; fa_q <= fb_q; da_q <= db_q;
						pb_q <= pc_q; fb_q <= fc_q; db_q <= dc_q;
						pc_q <= pb_q; fc_q <= fb_q; dc_q <= db_q;
						tb_q <= tc_q; tc_q <= tb_q;
					end
				end
				OP_FINAL: begin
					swb_q <= w_q == mb_q;
					pa_q <= pb_q; fa_q <= fb_q; da_q <= db_q;
					pb_q <= nb;
				end
				default: ;
			endcase
		end
	end

	// step work registers and result payload
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_SWAP:  tol_q <= val_t'({1'b0, (cmd.first || swapped) ? tc_q : tb_q});
			OP_MID:   mb_q <= val_t'(mid - pb_q);
			OP_TSIGN: begin
				tol_q <= (mb_q == '0) ? '0 : (mb_q[VW-1] ? -tol_q : tol_q);
				ba_q <= sat_sub(pb_q, pa_q);
			end
			OP_DDER:   d_q <= da_q;
			OP_DQ:     d_q <= quot;
			OP_M_FBD:  t1_q <= prod;
			OP_M_P:    p_q <= prod;
			OP_M_FADB: t2_q <= prod;
			OP_Q:      q_q <= sat_sub(t2_q, t1_q);
			OP_NEG: begin
				if (p_q[VW-1]) begin
					p_q <= sat_sub('0, p_q);
					q_q <= sat_sub('0, q_q);
				end
			end
			OP_M_QT:  t3_q <= prod;
			OP_M_MBQ: t4_q <= prod;
			OP_WTOL:  w_q <= tol_q;
			OP_WMB:   w_q <= mb_q;
			OP_WQUOT: w_q <= quot;
			OP_FINAL: begin
				np_q <= nb; fin_q <= 1'b0; bp_q <= '0; oe_q <= '0; br_q <= 1'b0;
			end
			OP_DONE_OUT: begin
				np_q <= '0; fin_q <= 1'b1; bp_q <= pb_q; oe_q <= pc_q;
				br_q <= fc_q[VW-1] ? (fb_q >= 0) : (fb_q <= 0);
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign next_point = np_q;
	assign finished = fin_q;
	assign best_point = bp_q;
	assign other_end = oe_q;
	assign bracketed = br_q;

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FINAL || cmd.op == OP_DONE_OUT) |=> out_valid_q)
		else $error("result register not loaded");

endmodule

// ===== rtl/dbrf_ctrl.sv =====
module dbrf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        mode,
	input  dbrf_pkg::status_t st,
	output dbrf_pkg::cmd_t    cmd
);
	import dbrf_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   first_q, first_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_IDLE;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			first_q <= first_d;
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		first_d = first_q;
		cmd.op = OP_NONE;
		cmd.first = first_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (mode)
						MODE_FIRST: begin
							cmd.op = OP_LOAD0;
							phase_d = PH_LOADED;
						end
						MODE_SECOND: begin
							cmd.op = OP_LOAD1;
							first_d = 1'b1;
							state_d = S_SWAP;
						end
						MODE_EVAL: begin
							if (phase_q == PH_WAIT) begin
								cmd.op = OP_LOAD2;
								first_d = 1'b0;
								state_d = S_SWAP;
							end
						end
						default: ;
					endcase
				end
			end
			S_SWAP: begin cmd.op = OP_SWAP; state_d = S_MID; end
			S_MID:  begin cmd.op = OP_MID;  state_d = S_CHECK; end
			S_CHECK: begin
				if (st.conv) begin
					state_d = S_DONE;
				end else if (st.plain_bisect) begin
					cmd.op = OP_WMB;
					state_d = S_FINAL;
				end else begin
					cmd.op = OP_TSIGN;
					state_d = S_DSEL;
				end
			end
			S_DSEL: begin
				if (st.ec_two) begin
					cmd.op = OP_DDER;
					state_d = S_M1;
				end else begin
					cmd.op = OP_DIV1;
					state_d = S_DWAIT1;
				end
			end
			S_DWAIT1: begin
				if (st.div_done) begin
					cmd.op = OP_DQ;
					state_d = S_M1;
				end
			end
			S_M1:  begin cmd.op = OP_M_FBD;  state_d = S_M2; end
			S_M2:  begin cmd.op = OP_M_P;    state_d = S_M3; end
			S_M3:  begin cmd.op = OP_M_FADB; state_d = S_Q; end
			S_Q:   begin cmd.op = OP_Q;      state_d = S_NEG; end
			S_NEG: begin cmd.op = OP_NEG;    state_d = S_M4; end
			S_M4:  begin cmd.op = OP_M_QT;   state_d = S_M5; end
			S_M5:  begin cmd.op = OP_M_MBQ;  state_d = S_CMP; end
			S_CMP: begin
				if (st.p_small) begin
					cmd.op = OP_WTOL;
					state_d = S_FINAL;
				end else if (st.p_lt) begin
					cmd.op = OP_DIV2;
					state_d = S_DWAIT2;
				end else begin
					cmd.op = OP_WMB;
					state_d = S_FINAL;
				end
			end
			S_DWAIT2: begin
				if (st.div_done) begin
					cmd.op = OP_WQUOT;
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				if (st.out_free) begin
					cmd.op = OP_FINAL;
					phase_d = PH_WAIT;
					state_d = S_IDLE;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.op = OP_DONE_OUT;
					phase_d = PH_DONE;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_final_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FINAL || cmd.op == OP_DONE_OUT) |-> st.out_free)
		else $error("result written over a pending transfer");

	a_stray_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode == MODE_EVAL && phase_q != PH_WAIT) |=> state_q == S_IDLE)
		else $error("unrequested evaluation started a step");

endmodule
